// File: rtl/ced_pkg.sv
// Shared types, codes and constants of the escape sequence decoder.
`default_nettype none

package ced_pkg;

   localparam int CED_QUEUE_DEPTH = 4;

   // Decoder modes
   localparam logic [1:0] MODE_NORMAL = 2'd0;
   localparam logic [1:0] MODE_ESCAPE = 2'd1;
   localparam logic [1:0] MODE_OCTAL  = 2'd2;

   localparam int OCTAL_MAX_DIGITS = 3;

   localparam logic [7:0] CHAR_NUL       = 8'h00;
   localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
   localparam logic [7:0] CHAR_DIGIT_0   = 8'h30;
   localparam logic [7:0] CHAR_DIGIT_7   = 8'h37;
   localparam logic [7:0] CHAR_B         = 8'h62;
   localparam logic [7:0] CHAR_F         = 8'h66;
   localparam logic [7:0] CHAR_N         = 8'h6E;
   localparam logic [7:0] CHAR_R         = 8'h72;
   localparam logic [7:0] CHAR_T         = 8'h74;
   localparam logic [7:0] CHAR_V         = 8'h76;

   localparam logic [7:0] CODE_BS  = 8'd8;
   localparam logic [7:0] CODE_FF  = 8'd12;
   localparam logic [7:0] CODE_LF  = 8'd10;
   localparam logic [7:0] CODE_CR  = 8'd13;
   localparam logic [7:0] CODE_TAB = 8'd9;
   localparam logic [7:0] CODE_VT  = 8'd11;

   // One queue entry: the results that one request causes (one or two).
   typedef struct packed {
      logic [7:0] byte0;
      logic       last0;
      logic       trail0;
      logic       has1;
      logic [7:0] byte1;
      logic       last1;
   } ced_entry_type;

   function automatic logic [7:0] escape_code(input logic [7:0] c);
      logic [7:0] code;
      case (c)
         CHAR_B:  code = CODE_BS;
         CHAR_F:  code = CODE_FF;
         CHAR_N:  code = CODE_LF;
         CHAR_R:  code = CODE_CR;
         CHAR_T:  code = CODE_TAB;
         CHAR_V:  code = CODE_VT;
         default: code = c;
      endcase
      return code;
   endfunction

endpackage

`default_nettype wire

// File: rtl/ced_req_if.sv
// Request channel: one source character per request.
`default_nettype none

interface ced_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;

   modport source (output valid, output in_byte, input ready);
   modport sink   (input valid, input in_byte, output ready);
endinterface

`default_nettype wire

// File: rtl/ced_rsp_if.sv
// Response channel: decoded characters and terminators, zero to two per request.
`default_nettype none

interface ced_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       is_last;
   logic       trailing_backslash;

   modport source (output valid, output out_byte, output is_last,
                   output trailing_backslash, input ready);
   modport sink   (input valid, input out_byte, input is_last,
                   input trailing_backslash, output ready);
endinterface

`default_nettype wire

// File: rtl/ced_front.sv
// Front end: takes source characters, tracks escape state, builds queue entries.
`default_nettype none

module ced_front
   import ced_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   ced_req_if.sink      req,
   input  wire logic    queue_full,
   output logic         push,
   output ced_entry_type push_entry
);

   logic [1:0] mode_ff, mode_in;
   logic [7:0] oval_ff, oval_in;
   logic [1:0] odig_ff, odig_in;

   logic       accept;
   logic       produce;
   logic       is_digit;
   logic [7:0] c;
   logic [7:0] oval_next;

   assign req.ready = !queue_full;
   assign accept    = req.valid && req.ready;
   assign push      = accept && produce;
   assign c         = req.in_byte;
   assign is_digit  = c inside {[CHAR_DIGIT_0:CHAR_DIGIT_7]};
   assign oval_next = {oval_ff[4:0], c[2:0]};

   always_comb begin
      mode_in    = mode_ff;
      oval_in    = oval_ff;
      odig_in    = odig_ff;
      produce    = 1'b0;
      push_entry = '0;
      case (mode_ff)
         MODE_ESCAPE: begin
            if (c == CHAR_NUL) begin
               produce           = 1'b1;
               push_entry.last0  = 1'b1;
               push_entry.trail0 = 1'b1;
               mode_in           = MODE_NORMAL;
               oval_in           = '0;
               odig_in           = '0;
            end else if (is_digit) begin
               mode_in = MODE_OCTAL;
               oval_in = {5'd0, c[2:0]};
               odig_in = 2'd1;
            end else begin
               produce          = 1'b1;
               push_entry.byte0 = escape_code(c);
               mode_in          = MODE_NORMAL;
            end
         end
         MODE_OCTAL: begin
            if (is_digit) begin
               if (odig_ff == 2'(OCTAL_MAX_DIGITS - 1)) begin
                  produce          = 1'b1;
                  push_entry.byte0 = oval_next;
                  mode_in          = MODE_NORMAL;
                  oval_in          = '0;
                  odig_in          = '0;
               end else begin
                  oval_in = oval_next;
                  odig_in = odig_ff + 2'd1;
               end
            end else begin
               // Flush the gathered byte, then handle the ending character.
               produce          = 1'b1;
               push_entry.byte0 = oval_ff;
               oval_in          = '0;
               odig_in          = '0;
               if (c == CHAR_NUL) begin
                  push_entry.has1  = 1'b1;
                  push_entry.last1 = 1'b1;
                  mode_in          = MODE_NORMAL;
               end else if (c == CHAR_BACKSLASH) begin
                  mode_in = MODE_ESCAPE;
               end else begin
                  push_entry.has1  = 1'b1;
                  push_entry.byte1 = c;
                  mode_in          = MODE_NORMAL;
               end
            end
         end
         default: begin
            if (c == CHAR_NUL) begin
               produce          = 1'b1;
               push_entry.last0 = 1'b1;
               mode_in          = MODE_NORMAL;
               oval_in          = '0;
               odig_in          = '0;
            end else if (c == CHAR_BACKSLASH) begin
               mode_in = MODE_ESCAPE;
            end else begin
               produce          = 1'b1;
               push_entry.byte0 = c;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_NORMAL;
         oval_ff <= '0;
         odig_ff <= '0;
      end else if (accept) begin
         mode_ff <= mode_in;
         oval_ff <= oval_in;
         odig_ff <= odig_in;
      end
   end

`ifndef ASSERT_OFF
   a_digits_only_in_octal: assert property (@(posedge clock) disable iff (reset)
      (odig_ff != 2'd0) |-> (mode_ff == MODE_OCTAL && odig_ff != 2'd3))
      else $error("octal digit count outside an octal run");
   a_terminator_clears: assert property (@(posedge clock) disable iff (reset)
      (push && (push_entry.last0 || push_entry.last1)) |=>
         (mode_ff == MODE_NORMAL && odig_ff == 2'd0 && oval_ff == 8'd0))
      else $error("state not cleared after terminator");
`endif

endmodule

`default_nettype wire

// File: rtl/ced_queue.sv
// Entry queue between the front end and the response back end.
`default_nettype none

module ced_queue
   import ced_pkg::*;
#(
   parameter int QUEUE_DEPTH = CED_QUEUE_DEPTH
) (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           push,
   input  wire ced_entry_type  push_entry,
   input  wire logic           pop,
   output ced_entry_type       head,
   output logic                empty,
   output logic                full
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   ced_entry_type entries_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign empty = (count_ff == '0);
   assign full  = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign head  = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

`ifndef ASSERT_OFF
   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      full |-> !push)
      else $error("push into a full queue");
   a_no_pop_when_empty: assert property (@(posedge clock) disable iff (reset)
      empty |-> !pop)
      else $error("pop from an empty queue");
`endif

endmodule

`default_nettype wire

// File: rtl/ced_back.sv
// Back end: walks the results of the head entry onto the response channel.
`default_nettype none

module ced_back
   import ced_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire ced_entry_type head,
   input  wire logic          empty,
   output logic               pop,
   ced_rsp_if.source          rsp
);

   logic second_ff, second_in;
   logic fire;

   assign rsp.valid              = !empty;
   assign rsp.out_byte           = second_ff ? head.byte1 : head.byte0;
   assign rsp.is_last            = second_ff ? head.last1 : head.last0;
   assign rsp.trailing_backslash = second_ff ? 1'b0 : head.trail0;

   assign fire = rsp.valid && rsp.ready;
   // Drop the entry once its last result has gone out.
   assign pop  = fire && (second_ff || !head.has1);

   always_comb begin
      second_in = second_ff;
      if (fire) begin
         second_in = !pop;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         second_ff <= 1'b0;
      end else begin
         second_ff <= second_in;
      end
   end

`ifndef ASSERT_OFF
   a_second_needs_pair: assert property (@(posedge clock) disable iff (reset)
      second_ff |-> (!empty && head.has1))
      else $error("second result selected without a paired entry");
`endif

endmodule

`default_nettype wire

// File: rtl/c_escape_sequence_decoder_unit.sv
// C string escape decoder: one source byte per request, decoded bytes per response.
// Takes one source character per cycle while the entry queue has room, and
// answers with decoded characters: backslash escapes (octal runs of one to three
// digits, b f n r t v, anything else verbatim) are resolved, and a zero byte
// yields a terminator response with is_last set, plus trailing_backslash when
// the string ended just after a backslash. A request causes zero, one or two
// responses; they are written into the entry queue and offered from its head. The
// response side sends one result per cycle while the receiver is ready, so a request
// causing two results (an octal run ended by any character but a backslash) takes two
// responses; the QUEUE_DEPTH-entry queue between the decoder and the response side
// absorbs such bursts and response stalls; requests are refused only while it is full.
`default_nettype none

module c_escape_sequence_decoder_unit
   import ced_pkg::*;
#(
   parameter int QUEUE_DEPTH = CED_QUEUE_DEPTH
) (
   input  wire logic clock,
   input  wire logic reset,
   ced_req_if.sink   req,
   ced_rsp_if.source rsp
);

   logic          push;
   ced_entry_type push_entry;
   logic          pop;
   ced_entry_type head;
   logic          empty;
   logic          full;

   ced_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req),
      .queue_full (full),
      .push       (push),
      .push_entry (push_entry)
   );

   ced_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .empty      (empty),
      .full       (full)
   );

   ced_back u_back (
      .clock (clock),
      .reset (reset),
      .head  (head),
      .empty (empty),
      .pop   (pop),
      .rsp   (rsp)
   );

endmodule

`default_nettype wire

// File: tb/c_escape_sequence_decoder_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the C string escape decoder: directed escapes, then random strings.
module c_escape_sequence_decoder_unit_tb;
   import ced_pkg::*;

   localparam int LIMIT_CYCLES     = 200000;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int MAX_REPORTS      = 20;
   localparam int DRAIN_CYCLES     = 20;

   typedef struct {
      logic [7:0] ch;
      logic       last;
      logic       trail;
   } decoded_char_type;

   logic clock;
   logic reset;

   ced_req_if req_ch ();
   ced_rsp_if rsp_ch ();

   c_escape_sequence_decoder_unit dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   logic [7:0]       source_bytes[$];
   decoded_char_type expected_chars[$];

   // Decoder state as this testbench tracks it
   logic [1:0] dec_mode;
   logic [7:0] oct_value;
   int         oct_digits;

   int sender_idle_pct;
   int receiver_stall_pct;
   int long_hold_arm;
   int long_hold_seen;
   int hold_left;
   bit req_taken;

   int cycle_count;
   int errors;
   int requests_taken;
   int chars_checked;
   int strings_closed;
   int octal_bytes;
   int trailing_flags;

   always #4 clock = ~clock;

   function automatic bit is_octal(input logic [7:0] c);
      return c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_7;
   endfunction

   task automatic expect_char(input logic [7:0] ch, input logic last, input logic trail);
      decoded_char_type e;
      e.ch    = ch;
      e.last  = last;
      e.trail = trail;
      expected_chars.insert(expected_chars.size(), e);
      if (last) begin
         strings_closed++;
         if (trail) trailing_flags++;
      end
   endtask

   task automatic clear_decoder();
      dec_mode   = MODE_NORMAL;
      oct_value  = '0;
      oct_digits = 0;
   endtask

   task automatic decode_plain(input logic [7:0] c);
      if (c == CHAR_NUL) begin
         expect_char(CHAR_NUL, 1'b1, 1'b0);
         clear_decoder();
      end else if (c == CHAR_BACKSLASH) begin
         dec_mode = MODE_ESCAPE;
      end else begin
         expect_char(c, 1'b0, 1'b0);
      end
   endtask

   task automatic decode_char(input logic [7:0] c);
      logic [7:0] code;
      case (dec_mode)
         MODE_ESCAPE: begin
            if (c == CHAR_NUL) begin
               expect_char(CHAR_NUL, 1'b1, 1'b1);
               clear_decoder();
            end else if (is_octal(c)) begin
               dec_mode   = MODE_OCTAL;
               oct_value  = c - CHAR_DIGIT_0;
               oct_digits = 1;
            end else begin
               case (c)
                  CHAR_B:  code = CODE_BS;
                  CHAR_F:  code = CODE_FF;
                  CHAR_N:  code = CODE_LF;
                  CHAR_R:  code = CODE_CR;
                  CHAR_T:  code = CODE_TAB;
                  CHAR_V:  code = CODE_VT;
                  default: code = c;
               endcase
               expect_char(code, 1'b0, 1'b0);
               dec_mode = MODE_NORMAL;
            end
         end
         MODE_OCTAL: begin
            if (is_octal(c)) begin
               // keep only the low 8 bits of the octal value
               oct_value = (oct_value << 3) + (c - CHAR_DIGIT_0);
               if (oct_digits + 1 >= OCTAL_MAX_DIGITS) begin
                  expect_char(oct_value, 1'b0, 1'b0);
                  octal_bytes++;
                  clear_decoder();
               end else begin
                  oct_digits++;
               end
            end else begin
               // flush the gathered byte, then treat the ending character as plain
               expect_char(oct_value, 1'b0, 1'b0);
               octal_bytes++;
               clear_decoder();
               decode_plain(c);
            end
         end
         default: decode_plain(c);
      endcase
   endtask

   task automatic report_mismatch(input string msg);
      errors++;
      if (errors <= MAX_REPORTS) $display("[cycle %0d] mismatch: %s", cycle_count, msg);
   endtask

   function automatic void add_byte(input logic [7:0] b);
      source_bytes.insert(source_bytes.size(), b);
   endfunction

   function automatic void push_text(input string s);
      for (int i = 0; i < s.len(); i++) add_byte(s[i]);
   endfunction

   // Append one string of plain characters, escapes and random bytes; returns its length.
   function automatic int push_random_string();
      int         start;
      int         n_tokens;
      int         digits;
      int         tail;
      logic [7:0] c;
      start    = source_bytes.size();
      n_tokens = $urandom_range(1, 12);
      repeat (n_tokens) begin
         case ($urandom_range(0, 9))
            3: begin
               add_byte(CHAR_BACKSLASH);
               case ($urandom_range(0, 5))
                  0:       c = CHAR_B;
                  1:       c = CHAR_F;
                  2:       c = CHAR_N;
                  3:       c = CHAR_R;
                  4:       c = CHAR_T;
                  default: c = CHAR_V;
               endcase
               add_byte(c);
            end
            4: begin
               add_byte(CHAR_BACKSLASH);
               do c = 8'($urandom_range(1, 255)); while (is_octal(c));
               add_byte(c);
            end
            5, 6: begin
               add_byte(CHAR_BACKSLASH);
               digits = $urandom_range(1, 3);
               repeat (digits) add_byte(8'($urandom_range(CHAR_DIGIT_0, CHAR_DIGIT_7)));
            end
            7: add_byte(8'($urandom_range(0, 255)));
            default: begin
               do c = 8'($urandom_range(1, 255)); while (c == CHAR_BACKSLASH);
               add_byte(c);
            end
         endcase
      end
      tail = $urandom_range(0, 19);
      if (tail < 2) begin
         add_byte(CHAR_BACKSLASH);
         add_byte(CHAR_NUL);
      end else if (tail > 2) begin
         add_byte(CHAR_NUL);
      end
      // tail == 2: leave the string open into the next one
      return source_bytes.size() - start;
   endfunction

   task automatic wait_drained();
      while (source_bytes.size() != 0 || expected_chars.size() != 0) @(posedge clock);
   endtask

   task automatic run_phase(input int idle_pct, input int stall_pct, input int n_items,
                            input bit long_hold);
      int pushed;
      sender_idle_pct    = idle_pct;
      receiver_stall_pct = stall_pct;
      if (long_hold) long_hold_arm++;
      pushed = 0;
      while (pushed < n_items) pushed += push_random_string();
      wait_drained();
   endtask

   // Request driver: hold an offered request until taken, else maybe offer the next.
   always @(negedge clock) begin
      if (reset) begin
         req_ch.valid   <= 1'b0;
         req_ch.in_byte <= '0;
      end else if (req_ch.valid && !req_taken) begin
         req_ch.valid <= 1'b1;
      end else if (source_bytes.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
         req_ch.valid   <= 1'b1;
         req_ch.in_byte <= source_bytes[0];
      end else begin
         req_ch.valid   <= 1'b0;
         req_ch.in_byte <= 8'($urandom_range(0, 255));
      end
   end

   // Result receiver: random stalls, plus a long hold-off when armed.
   always @(negedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (long_hold_arm != long_hold_seen) begin
            long_hold_seen = long_hold_arm;
            hold_left      = LONG_HOLD_CYCLES;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= $urandom_range(0, 99) >= receiver_stall_pct;
         end
      end
   end

   // Monitor: check results against the oldest expectation, predict on each request.
   always @(posedge clock) begin : monitor
      decoded_char_type want;
      req_taken = 1'b0;
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            chars_checked++;
            if (expected_chars.size() == 0) begin
               report_mismatch($sformatf("unexpected result out_byte=%02h is_last=%0b",
                                         rsp_ch.out_byte, rsp_ch.is_last));
            end else begin
               want = expected_chars.pop_front();
               if (rsp_ch.out_byte !== want.ch)
                  report_mismatch($sformatf("out_byte %02h, want %02h",
                                            rsp_ch.out_byte, want.ch));
               if (rsp_ch.is_last !== want.last)
                  report_mismatch($sformatf("is_last %0b, want %0b",
                                            rsp_ch.is_last, want.last));
               if (rsp_ch.trailing_backslash !== want.trail)
                  report_mismatch($sformatf("trailing_backslash %0b, want %0b",
                                            rsp_ch.trailing_backslash, want.trail));
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            req_taken = 1'b1;
            requests_taken++;
            void'(source_bytes.pop_front());
            decode_char(req_ch.in_byte);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("tb: failure");
         $finish;
      end
   end

   initial begin
      clock              = 1'b0;
      reset              = 1'b1;
      req_ch.valid       = 1'b0;
      req_ch.in_byte     = '0;
      rsp_ch.ready       = 1'b0;
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      long_hold_arm      = 0;
      long_hold_seen     = 0;
      hold_left          = 0;
      req_taken          = 1'b0;
      cycle_count        = 0;
      errors             = 0;
      requests_taken     = 0;
      chars_checked      = 0;
      strings_closed     = 0;
      octal_bytes        = 0;
      trailing_flags     = 0;
      clear_decoder();

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // named escapes, a wrapping three-digit octal, an octal run cut by a letter,
      // end of string inside an octal run, end of string after a lone backslash
      push_text("\\b\\f\\n\\r\\t\\v\\777\\5x\\12");
      add_byte(CHAR_NUL);
      push_text("\\");
      add_byte(CHAR_NUL);
      @(posedge clock);

      run_phase(0, 0, 72, 1'b0);
      run_phase(86, 0, 72, 1'b0);
      run_phase(0, 86, 72, 1'b0);
      run_phase(32, 32, 72, 1'b0);
      run_phase(0, 0, 72, 1'b1);

      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d requests and %0d results: %0d strings closed, %0d after a backslash,",
               requests_taken, chars_checked, strings_closed, trailing_flags);
      $display("%0d octal bytes, under free flow, sender gaps, receiver stalls and a long hold-off",
               octal_bytes);
      if (errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
